// ===== design/mexp_pkg.sv =====
package mexp_pkg;

    // Width of every numeric field on the ports
    localparam int FIELD_W = 32;

    // Default operand width used inside the datapath
    localparam int DATA_WIDTH_DEF = 32;

    // Exponent offset for the Fermat inverse: modulus minus this
    localparam int FERMAT_OFFSET = 2;

    typedef enum logic {
        OP_POWER   = 1'b0,
        OP_INVERSE = 1'b1
    } t_opcode;

endpackage

// ===== design/mexp_modmul.sv =====
// Bit-serial interleaved modular multiplier: r = a * b mod m.
// One bit of a per cycle, MSB first; b must already be below m.
module mexp_modmul
    import mexp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    input  logic [DATA_WIDTH-1:0] i_m,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_r
);

    localparam int DW = DATA_WIDTH;
    localparam int RW = DATA_WIDTH + 2;
    localparam int CW = $clog2(DATA_WIDTH);

    typedef enum logic {
        MM_IDLE,
        MM_RUN
    } t_mm_state;

    t_mm_state       r_state;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [DW-1:0]   r_a_sh;
    logic [DW-1:0]   r_b;
    logic [DW-1:0]   r_r;

    logic [RW-1:0]   n_sum;
    logic [RW-1:0]   n_m1;
    logic [RW-1:0]   n_m2;
    logic [RW-1:0]   n_red;

    // 2r + bit*b stays below 3m, so one subtract of m or 2m brings it back under m
    always_comb begin
        n_sum = {1'b0, r_r, 1'b0} + {2'b00, (r_a_sh[DW-1] ? r_b : '0)};
        n_m1  = {2'b00, i_m};
        n_m2  = {1'b0, i_m, 1'b0};
        if (n_sum >= n_m2) begin
            n_red = n_sum - n_m2;
        end else if (n_sum >= n_m1) begin
            n_red = n_sum - n_m1;
        end else begin
            n_red = n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MM_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == MM_RUN) && (r_cnt == '0);
            case (r_state)
                MM_IDLE: begin
                    if (i_start) begin
                        r_a_sh  <= i_a;
                        r_b     <= i_b;
                        r_r     <= '0;
                        r_cnt   <= CW'(DW - 1);
                        r_state <= MM_RUN;
                    end
                end
                MM_RUN: begin
                    r_r    <= n_red[DW-1:0];
                    r_a_sh <= {r_a_sh[DW-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_state <= MM_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: begin
                    r_state <= MM_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_r    = r_r;

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == MM_IDLE)
        else $error("multiplier started while busy");

    a_done_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_r < i_m)
        else $error("multiplier result not reduced");

    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state) == MM_RUN)
        else $error("done without a run");

endmodule

// ===== design/modular_exponentiation_unit.sv =====
// Modular exponentiation: result = base ^ exponent mod modulus.
// Input channel i_valid / o_stall carries opcode, base, exponent, modulus;
// an item is taken when i_valid is high and o_stall is low. Opcode 1 uses
// modulus - 2 as the exponent (Fermat inverse) and ignores the exponent field.
// Output channel o_valid / i_stall carries result and error; a result is taken
// when o_valid is high and i_stall is low, and holds steady while stalled.
// An unusable modulus (zero, or below two for an inverse) gives error 1 and
// result 0; a zero effective exponent gives 1 at once.
// One bit-serial modular multiplier does every product. A first pass reduces
// the base; then each exponent bit up to the top set bit passes once through
// ST_NEXT, a set bit adds a multiply, and every bit below the top one a square.
// Special cases (error or zero exponent) skip the multiplier and go straight to
// ST_DONE. The block leaves ST_DONE as it loads the output register, so o_stall
// falls in the same cycle that o_valid rises.
// o_stall is high while an item is at work. The output register lets the next
// item be taken while a result waits; a finished item waits for that register.
// Synchronous reset empties the block; no clearing pass is needed.
module modular_exponentiation_unit
    import mexp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic [FIELD_W-1:0] i_base,
    input  logic [FIELD_W-1:0] i_exponent,
    input  logic [FIELD_W-1:0] i_modulus,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [FIELD_W-1:0] o_result,
    output logic               o_error
);

    localparam int DW = DATA_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_NEXT,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } t_state;

    t_state          r_state;
    logic [DW-1:0]   r_m;
    logic [DW-1:0]   r_exp;
    logic [DW-1:0]   r_acc;
    logic [DW-1:0]   r_b;
    logic            r_err;
    logic            r_mm_start;
    logic [DW-1:0]   r_mm_a;
    logic [DW-1:0]   r_mm_b;
    logic            r_out_valid;
    logic [DW-1:0]   r_out_result;
    logic            r_out_error;

    logic [DW-1:0]   n_m;
    logic [DW-1:0]   n_exp;
    logic [DW-1:0]   n_one;
    logic            n_err;
    logic            n_mm_start;
    logic            out_take;
    logic            out_load;
    logic            mm_done;
    logic [DW-1:0]   mm_r;

    always_comb begin
        n_m = i_modulus[DW-1:0];
        if (i_opcode == OP_INVERSE) begin
            n_err = n_m < DW'(FERMAT_OFFSET);
            n_exp = n_m - DW'(FERMAT_OFFSET);
        end else begin
            n_err = n_m == '0;
            n_exp = i_exponent[DW-1:0];
        end
        // 1 mod m, so the base reduction also works for a modulus of one
        n_one = (n_m == DW'(1)) ? '0 : DW'(1);
    end

    assign out_take = r_out_valid && !i_stall;
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || !i_stall);
    assign o_stall  = r_state != ST_IDLE;

    assign n_mm_start = (r_state == ST_IDLE && i_valid && !n_err && n_exp != '0) ||
                        (r_state == ST_NEXT) ||
                        (r_state == ST_MUL && mm_done && r_exp[DW-1:1] != '0);

    mexp_modmul #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mm_start),
        .i_a     (r_mm_a),
        .i_b     (r_mm_b),
        .i_m     (r_m),
        .o_done  (mm_done),
        .o_r     (mm_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mm_start  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mm_start <= n_mm_start;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_m   <= n_m;
                        r_exp <= n_exp;
                        r_acc <= DW'(1);
                        r_err <= n_err;
                        if (n_err || n_exp == '0) begin
                            r_state <= ST_DONE;
                        end else begin
                            // first pass: base * (1 mod m) reduces the base
                            r_mm_a     <= i_base[DW-1:0];
                            r_mm_b     <= n_one;
                            r_state    <= ST_REDUCE;
                        end
                    end
                end
                ST_REDUCE: begin
                    if (mm_done) begin
                        r_b     <= mm_r;
                        r_state <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    if (r_exp[0]) begin
                        r_mm_a  <= r_acc;
                        r_mm_b  <= r_b;
                        r_state <= ST_MUL;
                    end else begin
                        // clear low bit means a higher set bit remains
                        r_mm_a  <= r_b;
                        r_mm_b  <= r_b;
                        r_exp   <= r_exp >> 1;
                        r_state <= ST_SQR;
                    end
                end
                ST_MUL: begin
                    if (mm_done) begin
                        r_acc <= mm_r;
                        if (r_exp[DW-1:1] == '0) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_mm_a     <= r_b;
                            r_mm_b     <= r_b;
                            r_exp      <= r_exp >> 1;
                            r_state    <= ST_SQR;
                        end
                    end
                end
                ST_SQR: begin
                    if (mm_done) begin
                        r_b     <= mm_r;
                        r_state <= ST_NEXT;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_out_result <= r_err ? '0 : r_acc;
                        r_out_error  <= r_err;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = FIELD_W'(r_out_result);
    assign o_error  = r_out_error;

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_done |-> (r_state == ST_REDUCE || r_state == ST_MUL || r_state == ST_SQR))
        else $error("multiplier result arrived unexpectedly");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_error) |-> r_out_result == '0)
        else $error("error item with nonzero result");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_state != ST_IDLE)
        else $error("accepted item not started");

    a_start_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mm_start |-> (r_state == ST_REDUCE || r_state == ST_MUL || r_state == ST_SQR))
        else $error("multiplier started outside a wait state");

endmodule

// ===== sim/tb_modular_exponentiation_unit.sv =====
`timescale 1ns / 1ps

module tb_modular_exponentiation_unit;
    import mexp_pkg::*;

    localparam int N_DIRECTED   = 22;
    localparam int N_RANDOM     = 250;
    localparam int IDLE_LIMIT   = 40000;
    localparam int HOLD_OFF_AT  = 60;
    localparam int HOLD_OFF_LEN = 8000;
    localparam int PAUSE_AT     = 110;
    localparam int DRAIN_CYCLES = 2400;

    typedef struct {
        logic [FIELD_W-1:0] result;
        logic               error;
    } t_power_out;

    typedef struct {
        t_opcode            op;
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] expo;
        logic [FIELD_W-1:0] modulus;
        bit                 known;
        logic [FIELD_W-1:0] res;
        logic               err;
    } t_directed_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_opcode;
    logic [FIELD_W-1:0] i_base;
    logic [FIELD_W-1:0] i_exponent;
    logic [FIELD_W-1:0] i_modulus;
    logic               o_valid;
    logic               i_stall;
    logic [FIELD_W-1:0] o_result;
    logic               o_error;

    t_power_out awaited_results[$];
    int         mismatches = 0;

    // known: expected value typed in; otherwise predicted
    t_directed_row directed_rows [N_DIRECTED] = '{
        '{OP_POWER,   32'd2,         32'd10,        32'd1000,      1'b1, 32'd24,  1'b0},
        '{OP_POWER,   32'd9,         32'd0,         32'd1,         1'b1, 32'd1,   1'b0},
        '{OP_POWER,   32'd0,         32'd0,         32'd0,         1'b1, 32'd0,   1'b1},
        '{OP_INVERSE, 32'd5,         32'd7,         32'd0,         1'b1, 32'd0,   1'b1},
        '{OP_INVERSE, 32'hFFFFFFFF,  32'hFFFFFFFF,  32'd1,         1'b1, 32'd0,   1'b1},
        '{OP_INVERSE, 32'hFFFFFFFF,  32'hFFFFFFFF,  32'd2,         1'b1, 32'd1,   1'b0},
        '{OP_POWER,   32'd7,         32'd5,         32'd1,         1'b1, 32'd0,   1'b0},
        '{OP_POWER,   32'hFFFFFFFF,  32'hFFFFFFFF,  32'hFFFFFFFF,  1'b0, 32'd0,   1'b0},
        '{OP_POWER,   32'd0,         32'hFFFFFFFF,  32'hFFFFFFFF,  1'b1, 32'd0,   1'b0},
        '{OP_POWER,   32'd1,         32'hFFFFFFFF,  32'hFFFFFFFF,  1'b1, 32'd1,   1'b0},
        '{OP_POWER,   32'hFFFFFFFF,  32'd1,         32'd1000,      1'b1, 32'd295, 1'b0},
        '{OP_INVERSE, 32'd3,         32'd0,         32'd7,         1'b1, 32'd5,   1'b0},
        '{OP_INVERSE, 32'hFFFFFFFF,  32'd0,         32'hFFFFFFFF,  1'b0, 32'd0,   1'b0},
        '{OP_INVERSE, 32'd0,         32'hFFFFFFFF,  32'hFFFFFFFB,  1'b1, 32'd0,   1'b0},
        '{OP_INVERSE, 32'd2,         32'd0,         32'hFFFFFFFB,  1'b0, 32'd0,   1'b0},
        '{OP_POWER,   32'd3,         32'hFFFFFFFF,  32'h80000000,  1'b0, 32'd0,   1'b0},
        '{OP_POWER,   32'd0,         32'd0,         32'd5,         1'b1, 32'd1,   1'b0},
        '{OP_POWER,   32'h80000000,  32'd2,         32'hFFFFFFFF,  1'b0, 32'd0,   1'b0},
        '{OP_INVERSE, 32'd2,         32'hA5A5A5A5,  32'd13,        1'b1, 32'd7,   1'b0},
        '{OP_POWER,   32'd5,         32'h80000000,  32'hFFFFFFFF,  1'b0, 32'd0,   1'b0},
        '{OP_POWER,   32'hFFFFFFFF,  32'hFFFFFFFF,  32'd0,         1'b1, 32'd0,   1'b1},
        '{OP_POWER,   32'h12345678,  32'hFEDCBA98,  32'hFFFFFFFE,  1'b0, 32'd0,   1'b0}
    };

    modular_exponentiation_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_opcode   (i_opcode),
        .i_base     (i_base),
        .i_exponent (i_exponent),
        .i_modulus  (i_modulus),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result),
        .o_error    (o_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Right-to-left square and multiply, exact 64-bit products
    function automatic t_power_out calc_mod_power(t_opcode op, logic [FIELD_W-1:0] b,
                                                  logic [FIELD_W-1:0] e,
                                                  logic [FIELD_W-1:0] m);
        t_power_out  o;
        bit   [63:0] acc;
        bit   [63:0] pw;
        bit   [63:0] ex;
        bit   [63:0] md;
        int          i;
        o.result = '0;
        o.error  = 1'b0;
        pw = 64'(b);
        ex = 64'(e);
        md = 64'(m);
        if (op == OP_INVERSE) begin
            if (md < FERMAT_OFFSET)
                o.error = 1'b1;
            else
                ex = md - FERMAT_OFFSET;
        end else if (md == 0) begin
            o.error = 1'b1;
        end
        if (!o.error) begin
            acc = 64'd1;
            for (i = 0; i < DATA_WIDTH_DEF; i++) begin
                if (ex == 0)
                    break;
                if (ex[0])
                    acc = (acc * pw) % md;
                pw = (pw * pw) % md;
                ex = ex >> 1;
            end
            o.result = acc[FIELD_W-1:0];
        end
        return o;
    endfunction

    function automatic int sender_gap(int k);
        int r;
        r = $urandom_range(0, 99);
        if ((k % 50) < 10)
            return 0;
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Offer one item and return at the edge that takes it
    task automatic push_item(input t_opcode op, input logic [FIELD_W-1:0] b,
                             input logic [FIELD_W-1:0] e, input logic [FIELD_W-1:0] m,
                             input bit known, input logic [FIELD_W-1:0] kres,
                             input logic kerr);
        t_power_out want;
        if (known) begin
            want.result = kres;
            want.error  = kerr;
        end else begin
            want = calc_mod_power(op, b, e, m);
        end
        i_valid    <= 1'b1;
        i_opcode   <= op;
        i_base     <= b;
        i_exponent <= e;
        i_modulus  <= m;
        do @(negedge i_clk); while (o_stall !== 1'b0);
        awaited_results.insert(awaited_results.size(), want);
        @(posedge i_clk);
    endtask

    task automatic idle_after_item(int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        int                 k;
        int                 r;
        t_opcode            op;
        logic [FIELD_W-1:0] b;
        logic [FIELD_W-1:0] e;
        logic [FIELD_W-1:0] m;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_opcode   <= OP_POWER;
        i_base     <= '0;
        i_exponent <= '0;
        i_modulus  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < N_DIRECTED; k++) begin
            push_item(directed_rows[k].op, directed_rows[k].base, directed_rows[k].expo,
                      directed_rows[k].modulus, directed_rows[k].known,
                      directed_rows[k].res, directed_rows[k].err);
            idle_after_item(sender_gap(k + 10));
        end

        for (k = 0; k < N_RANDOM; k++) begin
            r  = $urandom_range(0, 99);
            op = t_opcode'($urandom_range(0, 1));
            b  = $urandom;
            e  = $urandom;
            m  = $urandom;
            if (r < 8) begin
                m = $urandom_range(0, 2);
            end else if (r < 35) begin
                op = OP_POWER;
                e  = $urandom_range(0, 255);
            end else if (r < 50) begin
                op = OP_INVERSE;
            end else if (r < 56) begin
                op = OP_POWER;
                e  = '0;
            end else if (r < 64) begin
                m = $urandom_range(3, 1000);
            end
            push_item(op, b, e, m, 1'b0, '0, 1'b0);
            if (k == PAUSE_AT) begin
                // let the block drain completely before going on
                i_valid <= 1'b0;
                do @(posedge i_clk); while (awaited_results.size() != 0);
            end else begin
                idle_after_item(sender_gap(k));
            end
        end

        i_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : result_sink
        int         stall_left;
        int         seen;
        int         r;
        bit         held;
        t_power_out want;
        stall_left = 0;
        seen       = 0;
        held       = 1'b0;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected item: result %h error %b",
                             $time, o_result, o_error);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (o_result !== want.result) begin
                        $display("%0t: result mismatch: expected %h actual %h",
                                 $time, want.result, o_result);
                        mismatches++;
                    end
                    if (o_error !== want.error) begin
                        $display("%0t: error mismatch: expected %b actual %b",
                                 $time, want.error, o_error);
                        mismatches++;
                    end
                end
                seen++;
                // one long hold-off so the block fills and stalls its input
                if (seen == HOLD_OFF_AT && !held) begin
                    held       = 1'b1;
                    stall_left = HOLD_OFF_LEN;
                end
            end
            @(posedge i_clk);
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else if ((seen % 40) >= 20 && (seen % 40) < 30) begin
                i_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 85) begin
                    i_stall <= 1'b0;
                end else if (r < 97) begin
                    i_stall <= 1'b1;
                    stall_left = $urandom_range(0, 4);
                end else begin
                    i_stall <= 1'b1;
                    stall_left = $urandom_range(30, 400);
                end
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        wait (i_rst_n === 1'b1);
        while (idle < IDLE_LIMIT) begin
            @(negedge i_clk);
            if ((i_valid === 1'b1 && o_stall === 1'b0) ||
                (o_valid === 1'b1 && i_stall === 1'b0))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

endmodule
